>>> src/assert_macros.svh
// Assertion macros shared by the link frame receiver RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, held off during reset.
`define LFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, held off during reset.
`define LFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/lfr_pkg.sv
// Shared constants, codes and types of the link frame receiver.
// No dependencies; imported by the parser, queue, sequencer and top level.
`timescale 1ns / 1ps
package lfr_pkg;

    localparam int CHANNELS             = 16;
    localparam int CONFIG_PAYLOAD_BYTES = 768;
    localparam int HB_LEN               = 11 + 2 * CHANNELS;
    localparam int CFG_LEN              = 6 + CONFIG_PAYLOAD_BYTES;
    localparam int CNT_W                = 10;
    localparam int CH_W                 = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QDEPTH               = 2;
    localparam int QPTR_W               = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [7:0]       SYNC_HEARTBEAT = 8'hF7;
    localparam logic [7:0]       SYNC_TUNING    = 8'hF8;
    localparam logic [7:0]       SYNC_CONFIG    = 8'hF9;
    localparam logic [15:0]      REQUEST_NUMBER = 16'hFFFD;
    localparam logic [CNT_W-1:0] TUNING_RESET   = CNT_W'(64);
    localparam logic [CNT_W-1:0] TUNING_MIN     = CNT_W'(2);

    localparam int FLAG_ARMED    = 0;
    localparam int FLAG_FAILSAFE = 1;
    localparam int FLAG_RX       = 2;

    localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [1:0] KIND_TUNING    = 2'd1;
    localparam logic [1:0] KIND_CONFIG    = 2'd2;
    localparam logic [1:0] KIND_REQUEST   = 2'd3;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic        checksum_ok;
        logic        armed;
        logic        failsafe_active;
        logic        rx_receiving;
        logic [15:0] sequence_res;
        logic [7:0]  config_version;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [15:0] fingerprint;
        logic [15:0] channel_value;
        logic        last_of_run;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  hb_valid;
    } job_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        logic [15:0]     data;
    } hb_wr_t;

endpackage

>>> src/lfr_if.sv
// Valid/ready channel interfaces of the link frame receiver.
// No dependencies.
`timescale 1ns / 1ps
interface lfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic        checksum_ok;
    logic        armed;
    logic        failsafe_active;
    logic        rx_receiving;
    logic [15:0] sequence_res;
    logic [7:0]  config_version;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] fingerprint;
    logic [15:0] channel_value;
    logic        last_of_run;

    modport source (
        output valid, output frame_kind, output checksum_ok, output armed,
        output failsafe_active, output rx_receiving, output sequence_res,
        output config_version, output version_major, output version_minor,
        output fingerprint, output channel_value, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input frame_kind, input checksum_ok, input armed,
        input failsafe_active, input rx_receiving, input sequence_res,
        input config_version, input version_major, input version_minor,
        input fingerprint, input channel_value, input last_of_run,
        output ready
    );
endinterface

>>> src/lfr_front.sv
// Frame parser: sync hunt, byte count, running XOR, header capture.
// Depends on lfr_pkg and lfr_byte_if; pushes one job per frame to the queue.
`timescale 1ns / 1ps
module lfr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    lfr_byte_if.sink                  rx,
    input  logic [lfr_pkg::CNT_W-1:0] tuning_len,
    input  logic                      q_full,
    input  logic                      chan_done,
    output logic                      push,
    output lfr_pkg::job_t             job,
    output lfr_pkg::hb_wr_t           hb_wr
);
    import lfr_pkg::*;

    localparam logic [CNT_W-1:0] POS_FNUM_LO = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_FNUM_HI = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_FLAGS   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_SEQ_LO  = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_SEQ_HI  = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_CFGVER  = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_MAJOR   = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_MINOR   = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_FP_LO   = CNT_W'(8);
    localparam logic [CNT_W-1:0] POS_FP_HI   = CNT_W'(9);
    localparam logic [CNT_W-1:0] POS_CH0     = CNT_W'(10);
    localparam logic [CNT_W-1:0] HB_LEN_C    = CNT_W'(HB_LEN);
    localparam logic [CNT_W-1:0] CFG_LEN_C   = CNT_W'(CFG_LEN);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] exp_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       xor_reg;
    logic [15:0]      fnum_reg;
    logic             hold_reg, hold_next;

    logic [2:0]       flags_reg;
    logic [15:0]      seq_reg;
    logic [7:0]       cfgver_reg;
    logic [7:0]       major_reg;
    logic [7:0]       minor_reg;
    logic [15:0]      fp_reg;
    logic [7:0]       lo_reg;

    logic             accept, start, sync_hit, take, last, csum_ok;
    logic [1:0]       sync_kind, kind_cur;
    logic [CNT_W-1:0] sync_len, exp_cur, cnt_inc, tuning_clamped, pos_off;
    logic [7:0]       xor_cur;
    logic [15:0]      fnum_cur, fnum_new;

    assign rx.ready = !q_full && !hold_reg;
    assign accept   = rx.valid && rx.ready;
    assign start    = (count_reg == '0);
    assign tuning_clamped = (tuning_len < TUNING_MIN) ? TUNING_MIN : tuning_len;

    always_comb
    begin
        sync_hit  = 1'b1;
        sync_kind = KIND_HEARTBEAT;
        sync_len  = HB_LEN_C;
        case (rx.rx_byte)
            SYNC_HEARTBEAT:
            begin
                sync_kind = KIND_HEARTBEAT;
                sync_len  = HB_LEN_C;
            end
            SYNC_TUNING:
            begin
                sync_kind = KIND_TUNING;
                sync_len  = tuning_clamped;
            end
            SYNC_CONFIG:
            begin
                sync_kind = KIND_CONFIG;
                sync_len  = CFG_LEN_C;
            end
            default:
            begin
                sync_hit = 1'b0;
            end
        endcase
    end

    assign kind_cur = start ? sync_kind : kind_reg;
    assign exp_cur  = start ? sync_len : exp_reg;
    assign xor_cur  = start ? 8'h00 : xor_reg;
    assign fnum_cur = start ? 16'h0000 : fnum_reg;
    assign take     = accept && (!start || sync_hit);
    assign cnt_inc  = count_reg + CNT_W'(1);
    assign last     = (cnt_inc >= exp_cur);
    assign csum_ok  = (xor_cur == rx.rx_byte);
    assign push     = take && last;

    always_comb
    begin
        fnum_new = fnum_cur;
        if (kind_cur == KIND_CONFIG)
        begin
            if (count_reg == POS_FNUM_LO)
            begin
                fnum_new = {fnum_cur[15:8], rx.rx_byte};
            end
            else if (count_reg == POS_FNUM_HI)
            begin
                fnum_new = {rx.rx_byte, fnum_cur[7:0]};
            end
        end
    end

    // Build the frame summary; header fields only for a good heartbeat.
    always_comb
    begin
        job             = '0;
        job.item.checksum_ok = csum_ok;
        case (kind_cur)
            KIND_HEARTBEAT:
            begin
                job.item.frame_kind = KIND_HEARTBEAT;
                job.hb_valid        = csum_ok;
                if (csum_ok)
                begin
                    job.item.armed           = flags_reg[FLAG_ARMED];
                    job.item.failsafe_active = flags_reg[FLAG_FAILSAFE];
                    job.item.rx_receiving    = flags_reg[FLAG_RX];
                    job.item.sequence_res    = seq_reg;
                    job.item.config_version  = cfgver_reg;
                    job.item.version_major   = major_reg;
                    job.item.version_minor   = minor_reg;
                    job.item.fingerprint     = fp_reg;
                end
            end
            KIND_TUNING:
            begin
                job.item.frame_kind = KIND_TUNING;
            end
            default:
            begin
                job.item.frame_kind = (fnum_new == REQUEST_NUMBER) ? KIND_REQUEST
                                                                   : KIND_CONFIG;
            end
        endcase
        job.item.last_of_run = !job.hb_valid;
    end

    assign pos_off     = count_reg - POS_CH0;
    assign hb_wr.en    = take && (kind_cur == KIND_HEARTBEAT) && (count_reg >= POS_CH0)
                         && count_reg[0];
    assign hb_wr.addr  = pos_off[CH_W:1];
    assign hb_wr.data  = {rx.rx_byte, lo_reg};

    assign count_next = last ? '0 : cnt_inc;

    always_comb
    begin
        hold_next = hold_reg;
        if (push && job.hb_valid)
        begin
            hold_next = 1'b1;
        end
        else if (chan_done)
        begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            exp_reg   <= '0;
            kind_reg  <= KIND_HEARTBEAT;
            xor_reg   <= '0;
            fnum_reg  <= '0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            if (take)
            begin
                count_reg <= count_next;
                exp_reg   <= exp_cur;
                kind_reg  <= kind_cur;
                xor_reg   <= xor_cur ^ rx.rx_byte;
                fnum_reg  <= fnum_new;
            end
        end
    end

    // Capture heartbeat header bytes at their fixed positions.
    always_ff @(posedge clk)
    begin
        if (take && (kind_cur == KIND_HEARTBEAT))
        begin
            lo_reg <= rx.rx_byte;
            case (count_reg)
                POS_FLAGS:  flags_reg        <= rx.rx_byte[2:0];
                POS_SEQ_LO: seq_reg[7:0]     <= rx.rx_byte;
                POS_SEQ_HI: seq_reg[15:8]    <= rx.rx_byte;
                POS_CFGVER: cfgver_reg       <= rx.rx_byte;
                POS_MAJOR:  major_reg        <= rx.rx_byte;
                POS_MINOR:  minor_reg        <= rx.rx_byte;
                POS_FP_LO:  fp_reg[7:0]      <= rx.rx_byte;
                POS_FP_HI:  fp_reg[15:8]     <= rx.rx_byte;
                default:    ;
            endcase
        end
    end

endmodule

>>> src/lfr_queue.sv
// Short job queue between the frame parser and the result sequencer.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
module lfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfr_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output lfr_pkg::job_t dout
);
    import lfr_pkg::*;

    localparam logic [QPTR_W:0] DEPTH_C = (QPTR_W + 1)'(QDEPTH);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full  = (fill_reg == DEPTH_C);
    assign empty = (fill_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> src/lfr_back.sv
// Result sequencer: frame summary, then channel beats for a good heartbeat.
// Depends on lfr_pkg and lfr_result_if; holds the channel value memory.
`timescale 1ns / 1ps
module lfr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  lfr_pkg::job_t   head,
    output logic            pop,
    input  lfr_pkg::hb_wr_t hb_wr,
    output logic            chan_done,
    lfr_result_if.source    result
);
    import lfr_pkg::*;

    localparam logic S_JOB  = 1'b0;
    localparam logic S_CHAN = 1'b1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    logic [15:0]     ch_mem [CHANNELS];
    logic [15:0]     rd_data_reg;
    logic            rd_ok_reg, rd_ok_next;
    logic            state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    item_t           out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic            load_ok, emit_ch;

    assign load_ok   = !out_valid_reg || result.ready;
    assign pop       = (state_reg == S_JOB) && !q_empty && load_ok;
    assign emit_ch   = (state_reg == S_CHAN) && rd_ok_reg && load_ok;
    assign chan_done = emit_ch && (ch_reg == CH_LAST);
    assign rd_ok_next = (state_reg == S_CHAN) && !emit_ch;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            S_JOB:
            begin
                if (pop)
                begin
                    out_next       = head.item;
                    out_valid_next = 1'b1;
                    if (head.hb_valid)
                    begin
                        state_next = S_CHAN;
                        ch_next    = '0;
                    end
                end
            end
            S_CHAN:
            begin
                if (emit_ch)
                begin
                    out_next               = '0;
                    out_next.frame_kind    = KIND_HEARTBEAT;
                    out_next.checksum_ok   = 1'b1;
                    out_next.channel_value = rd_data_reg;
                    out_next.last_of_run   = (ch_reg == CH_LAST);
                    out_valid_next         = 1'b1;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_JOB;
                    end
                    else
                    begin
                        ch_next = ch_reg + CH_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_JOB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_JOB;
            ch_reg        <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (hb_wr.en)
        begin
            ch_mem[hb_wr.addr] <= hb_wr.data;
        end
        rd_data_reg <= ch_mem[ch_reg];
    end

    assign result.valid           = out_valid_reg;
    assign result.frame_kind      = out_reg.frame_kind;
    assign result.checksum_ok     = out_reg.checksum_ok;
    assign result.armed           = out_reg.armed;
    assign result.failsafe_active = out_reg.failsafe_active;
    assign result.rx_receiving    = out_reg.rx_receiving;
    assign result.sequence_res    = out_reg.sequence_res;
    assign result.config_version  = out_reg.config_version;
    assign result.version_major   = out_reg.version_major;
    assign result.version_minor   = out_reg.version_minor;
    assign result.fingerprint     = out_reg.fingerprint;
    assign result.channel_value   = out_reg.channel_value;
    assign result.last_of_run     = out_reg.last_of_run;

endmodule

>>> src/link_frame_receiver_unit.sv
// Top level of the link frame receiver: tuning length register and the
// parser, job queue and result sequencer. Depends on lfr_pkg, lfr_if, macros.
//
//   channel   dir   beat
//   rx        in    one received byte (rx_byte)
//   result    out   one report: frame summary or one heartbeat channel value
//   cfg_wr_*  in    tuning frame length, written when cfg_wr_en is high
//
// One byte is taken per cycle unless rx stalls; the frame summary beat
// follows the last byte through the two-entry job queue and output register.
// A good heartbeat then gives channel beats via a registered memory read; rx
// stalls from its last byte until the final channel beat is loaded.
// Reset clears all control state and sets the tuning length to 64; there is
// no clearing pass. A stalled result beat holds while bytes keep arriving.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module link_frame_receiver_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    lfr_byte_if.sink                  rx,
    lfr_result_if.source              result,
    input  logic                      cfg_wr_en,
    input  logic [lfr_pkg::CNT_W-1:0] cfg_wr_data
);
    import lfr_pkg::*;

    logic [CNT_W-1:0] tuning_reg;
    logic             push, pop, q_full, q_empty, chan_done;
    job_t             job, head;
    hb_wr_t           hb_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_reg <= TUNING_RESET;
        end
        else if (cfg_wr_en)
        begin
            tuning_reg <= cfg_wr_data;
        end
    end

    lfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .tuning_len (tuning_reg),
        .q_full     (q_full),
        .chan_done  (chan_done),
        .push       (push),
        .job        (job),
        .hb_wr      (hb_wr)
    );

    lfr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .dout  (head)
    );

    lfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .hb_wr     (hb_wr),
        .chan_done (chan_done),
        .result    (result)
    );

    `LFR_ASSERT_IMP(a_push_room, clk, rst_n, push, !q_full, "job pushed into full queue")
    `LFR_ASSERT_IMP(a_pop_data, clk, rst_n, pop, !q_empty, "job popped from empty queue")
    `LFR_ASSERT_IMP(a_store_quiet, clk, rst_n, hb_wr.en, !chan_done, "store written while draining")
    `LFR_ASSERT_NXT(a_last_chan, clk, rst_n, chan_done, result.valid && result.last_of_run, "final channel beat missing")

endmodule
